[rtl/core/tsnm_pkg.sv]
// Shared widths, codes and reset values of the timestamp nearest-match ring.
package tsnm_pkg;

    // Field widths of one record and of the configuration registers.
    localparam int TS_W      = 48;
    localparam int CODE_W    = 32;
    localparam int HANDLE_W  = 32;
    localparam int TOL_W     = 32;
    localparam int CAP_W     = 9;
    localparam int STATUS_W  = 3;
    localparam int REC_W     = TS_W + CODE_W + HANDLE_W;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    // Default number of slots in the ring.
    localparam int DEPTH_DEFAULT = 256;

    // Reset values of the configuration registers.
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(8000);
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 1'b1;

    // Request kinds.
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_STORED      = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_STORED_DROP = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_HIT         = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_MISS_EMPTY  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_MISS_TOL    = 3'd4;

    // Control from the sequencer to the distance unit.
    typedef struct packed {
        logic clear;  // forget the best candidate before a new search
        logic live;   // the candidate presented this cycle is a valid record
    } scan_ctrl_t;

    // Best candidate found so far.
    typedef struct packed {
        logic            found;
        logic [TS_W-1:0] ad;
    } best_t;

endpackage

[rtl/core/timestamp_nearest_match_ring.sv]
// Top level of the timestamp nearest-match ring store.
//
// A push (tuser 0) stores timestamp, codec code and payload handle at the tail
// of a ring of DEPTH slots; a pop (tuser 1) finds the stored record whose
// timestamp is nearest the request and, within the tolerance, returns it and
// removes it. One request is handled at a time and s_tready is low while it is
// in work. A push walks the head past removed slots and drops old records while
// the ring is at capacity, then stores. A pop walks the span from head to tail
// one slot per cycle through the single read port of the record memory, then
// moves the head past removed slots after a hit. Results wait in an output
// register until taken.
module timestamp_nearest_match_ring #(
    parameter int DEPTH = tsnm_pkg::DEPTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Request channel.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata: timestamp [47:0], codec_code [79:48], payload [111:80]
    input  logic [tsnm_pkg::REC_W-1:0]        s_tdata,
    // tuser: kind [0]
    input  logic [0:0]                        s_tuser,
    // Result channel.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata: found_timestamp [47:0], found_codec [79:48], found_payload [111:80]
    output logic [tsnm_pkg::REC_W-1:0]        m_tdata,
    // tuser: status [2:0]
    output logic [tsnm_pkg::STATUS_W-1:0]     m_tuser,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tsnm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tsnm_pkg::CFG_W-1:0]        cfg_data
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int TS_W  = tsnm_pkg::TS_W;
    localparam int CD_W  = tsnm_pkg::CODE_W;
    localparam int HD_W  = tsnm_pkg::HANDLE_W;
    localparam int REC_W = tsnm_pkg::REC_W;
    localparam logic [31:0]      DEPTH32   = 32'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_FETCH,
        ST_SKIP,
        ST_REPLY
    } state_t;

    // Sequencer and store control.
    state_t                         state_reg, state_next;
    logic [DEPTH-1:0]               valid_reg, valid_next;
    logic [IDX_W-1:0]               head_reg, head_next;
    logic [CNT_W-1:0]               span_reg, span_next;
    logic [tsnm_pkg::TOL_W-1:0]     tol_reg, tol_next;
    logic [tsnm_pkg::CAP_W-1:0]     cap_reg, cap_next;

    // Request being worked on.
    logic [TS_W-1:0]                req_ts_reg, req_ts_next;
    logic [CD_W-1:0]                req_codec_reg, req_codec_next;
    logic [HD_W-1:0]                req_handle_reg, req_handle_next;
    logic                           dropped_reg, dropped_next;

    // Search walk.
    logic [IDX_W-1:0]               rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]               k_reg, k_next;
    logic                           p1_live_reg, p1_live_next;
    logic [IDX_W-1:0]               p1_idx_reg, p1_idx_next;

    // Pending result and output register.
    logic [tsnm_pkg::STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [REC_W-1:0]               res_data_reg, res_data_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [tsnm_pkg::STATUS_W-1:0]  m_tuser_reg, m_tuser_next;
    logic [REC_W-1:0]               m_tdata_reg, m_tdata_next;

    // Record memory.
    logic [REC_W-1:0]               mem [DEPTH];
    logic [REC_W-1:0]               mem_q_reg;
    logic                           rd_en;
    logic [IDX_W-1:0]               rd_addr;
    logic                           wr_en;
    logic [IDX_W-1:0]               wr_addr;

    // Derived values.
    logic [31:0]                    cap32;
    logic [CNT_W-1:0]               cap_use;
    logic [SUM_W-1:0]               tail_sum;
    logic [IDX_W-1:0]               tail_idx;
    logic [IDX_W-1:0]               head_inc;
    logic [IDX_W-1:0]               rd_inc;
    logic                           scan_issue;
    logic                           hit;

    tsnm_pkg::scan_ctrl_t           scan_ctrl;
    tsnm_pkg::best_t                best;
    logic [IDX_W-1:0]               win_idx;
    logic                           scan_busy;

    // Capacity in use: zero acts as one, anything above DEPTH as DEPTH.
    assign cap32   = 32'(cap_reg);
    assign cap_use = (cap32 == 32'd0) ? CNT_W'(1) :
                     (cap32 > DEPTH32) ? DEPTH_CNT : CNT_W'(cap32);

    // Tail slot and wrapped increments of the ring pointers.
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(span_reg);
    assign tail_idx = (tail_sum >= DEPTH_SUM) ? IDX_W'(tail_sum - DEPTH_SUM)
                                              : IDX_W'(tail_sum);
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign rd_inc   = (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + 1'b1;

    assign scan_issue = (state_reg == ST_SCAN) && (k_reg != span_reg);
    assign hit        = best.found && (best.ad <= TS_W'(tol_reg));

    // Memory port control.
    assign rd_en   = scan_issue || ((state_reg == ST_DECIDE) && hit);
    assign rd_addr = (state_reg == ST_SCAN) ? rd_idx_reg : win_idx;
    assign wr_addr = tail_idx;

    assign scan_ctrl.clear = (state_reg == ST_IDLE);
    assign scan_ctrl.live  = p1_live_reg;

    tsnm_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (scan_ctrl),
        .cand_time (mem_q_reg[REC_W-1 -: TS_W]),
        .cand_idx  (p1_idx_reg),
        .req_ts    (req_ts_reg),
        .best      (best),
        .win_idx   (win_idx),
        .busy      (scan_busy)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        head_next       = head_reg;
        span_next       = span_reg;
        tol_next        = tol_reg;
        cap_next        = cap_reg;
        req_ts_next     = req_ts_reg;
        req_codec_next  = req_codec_reg;
        req_handle_next = req_handle_reg;
        dropped_next    = dropped_reg;
        rd_idx_next     = rd_idx_reg;
        k_next          = k_reg;
        p1_live_next    = scan_issue && valid_reg[rd_idx_reg];
        p1_idx_next     = rd_idx_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tuser_next    = m_tuser_reg;
        m_tdata_next    = m_tdata_reg;
        wr_en           = 1'b0;

        // The result register empties on a transfer.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // Configuration writes.
        if (cfg_valid) begin
            unique case (cfg_index)
                tsnm_pkg::CFG_TOLERANCE: tol_next = cfg_data[tsnm_pkg::TOL_W-1:0];
                tsnm_pkg::CFG_CAPACITY:  cap_next = cfg_data[tsnm_pkg::CAP_W-1:0];
                default:                 ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    req_ts_next     = s_tdata[TS_W-1:0];
                    req_codec_next  = s_tdata[TS_W +: CD_W];
                    req_handle_next = s_tdata[TS_W+CD_W +: HD_W];
                    dropped_next    = 1'b0;
                    rd_idx_next     = head_reg;
                    k_next          = '0;
                    res_data_next   = '0;
                    state_next      = (s_tuser[0] == tsnm_pkg::KIND_POP) ? ST_SCAN : ST_PUSH;
                end
            end
            // One step a cycle: skip a removed slot, drop the oldest record,
            // or store the new record at the tail.
            ST_PUSH: begin
                if ((span_reg != '0) && !valid_reg[head_reg]) begin
                    head_next = head_inc;
                    span_next = span_reg - 1'b1;
                end else if (span_reg >= cap_use) begin
                    dropped_next         = dropped_reg | valid_reg[head_reg];
                    valid_next[head_reg] = 1'b0;
                    head_next            = head_inc;
                    span_next            = span_reg - 1'b1;
                end else begin
                    wr_en                = 1'b1;
                    valid_next[tail_idx] = 1'b1;
                    span_next            = span_reg + 1'b1;
                    res_status_next      = dropped_reg ? tsnm_pkg::STATUS_STORED_DROP
                                                       : tsnm_pkg::STATUS_STORED;
                    state_next           = ST_REPLY;
                end
            end
            // Read one slot of the span per cycle.
            ST_SCAN: begin
                if (scan_issue) begin
                    rd_idx_next = rd_inc;
                    k_next      = k_reg + 1'b1;
                end else begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!p1_live_reg && !scan_busy) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!best.found) begin
                    res_status_next = tsnm_pkg::STATUS_MISS_EMPTY;
                    state_next      = ST_REPLY;
                end else if (!hit) begin
                    res_status_next = tsnm_pkg::STATUS_MISS_TOL;
                    state_next      = ST_REPLY;
                end else begin
                    state_next = ST_FETCH;
                end
            end
            // The winning record is in the read register; remove it.
            ST_FETCH: begin
                res_data_next       = mem_q_reg;
                res_status_next     = tsnm_pkg::STATUS_HIT;
                valid_next[win_idx] = 1'b0;
                state_next          = ST_SKIP;
            end
            // Move the head past removed slots.
            ST_SKIP: begin
                if ((span_reg != '0) && !valid_reg[head_reg]) begin
                    head_next = head_inc;
                    span_next = span_reg - 1'b1;
                end else begin
                    state_next = ST_REPLY;
                end
            end
            ST_REPLY: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = res_data_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            head_reg     <= '0;
            span_reg     <= '0;
            tol_reg      <= tsnm_pkg::TOL_RESET;
            cap_reg      <= tsnm_pkg::CAP_RESET;
            p1_live_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            dropped_reg  <= 1'b0;
            k_reg        <= '0;
        end else begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            head_reg     <= head_next;
            span_reg     <= span_next;
            tol_reg      <= tol_next;
            cap_reg      <= cap_next;
            p1_live_reg  <= p1_live_next;
            m_tvalid_reg <= m_tvalid_next;
            dropped_reg  <= dropped_next;
            k_reg        <= k_next;
        end
        req_ts_reg     <= req_ts_next;
        req_codec_reg  <= req_codec_next;
        req_handle_reg <= req_handle_next;
        rd_idx_reg     <= rd_idx_next;
        p1_idx_reg     <= p1_idx_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        m_tuser_reg    <= m_tuser_next;
        m_tdata_reg    <= m_tdata_next;
    end

    // Record memory: one write and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {req_ts_reg, req_handle_reg, req_codec_reg};
        end
        if (rd_en) begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tuser   = m_tuser_reg;
    // Memory words hold timestamp, handle, codec from the top bit down.
    assign m_tdata   = {m_tdata_reg[HD_W+CD_W-1 -: HD_W], m_tdata_reg[CD_W-1:0],
                        m_tdata_reg[REC_W-1 -: TS_W]};

    // The span never grows past the ring.
    a_span_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        span_reg <= DEPTH_CNT)
        else $error("span exceeds ring depth");

    // Between requests the head slot holds a record unless the ring is empty.
    a_head_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_REPLY) && (span_reg != '0)) |-> valid_reg[head_reg])
        else $error("head rests on a removed slot");

    // A returned record is removed from the store.
    a_hit_removed: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FETCH) |=> !valid_reg[$past(win_idx)])
        else $error("returned record still valid");

    // A result appears only out of the reply step.
    a_reply_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_REPLY))
        else $error("result raised outside reply");

endmodule

[rtl/core/tsnm_scan.sv]
// Distance unit: absolute timestamp difference and best-candidate tracking.
module tsnm_scan #(
    parameter int IDX_W = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  tsnm_pkg::scan_ctrl_t       ctrl,
    input  logic [tsnm_pkg::TS_W-1:0]  cand_time,
    input  logic [IDX_W-1:0]           cand_idx,
    input  logic [tsnm_pkg::TS_W-1:0]  req_ts,
    output tsnm_pkg::best_t            best,
    output logic [IDX_W-1:0]           win_idx,
    output logic                       busy
);

    logic [tsnm_pkg::TS_W:0]   d_fwd;
    logic [tsnm_pkg::TS_W-1:0] d_rev;
    logic                      later;

    logic                      p_live_reg;
    logic                      p_later_reg;
    logic [tsnm_pkg::TS_W-1:0] p_ad_reg;
    logic [IDX_W-1:0]          p_idx_reg;

    tsnm_pkg::best_t           best_reg;
    logic                      best_later_reg;
    logic [IDX_W-1:0]          win_idx_reg;
    logic                      better;

    // Both differences in parallel; the borrow of the forward one picks the sign.
    assign d_fwd = {1'b0, cand_time} - {1'b0, req_ts};
    assign d_rev = req_ts - cand_time;
    assign later = ~d_fwd[tsnm_pkg::TS_W] && (d_fwd[tsnm_pkg::TS_W-1:0] != '0);

    // Stage one: register the distance of the candidate.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_live_reg <= 1'b0;
        end else begin
            p_live_reg <= ctrl.live;
        end
        p_later_reg <= later;
        p_ad_reg    <= d_fwd[tsnm_pkg::TS_W] ? d_rev : d_fwd[tsnm_pkg::TS_W-1:0];
        p_idx_reg   <= cand_idx;
    end

    // A nearer record wins; at equal distance one not later than the request
    // replaces a later one, otherwise the older record stays.
    assign better = !best_reg.found || (p_ad_reg < best_reg.ad)
                    || ((p_ad_reg == best_reg.ad) && !p_later_reg && best_later_reg);

    // Stage two: keep the best candidate.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_reg.found <= 1'b0;
        end else if (ctrl.clear) begin
            best_reg.found <= 1'b0;
        end else if (p_live_reg && better) begin
            best_reg.found <= 1'b1;
        end
        if (p_live_reg && better) begin
            best_reg.ad    <= p_ad_reg;
            best_later_reg <= p_later_reg;
            win_idx_reg    <= p_idx_reg;
        end
    end

    assign best    = best_reg;
    assign win_idx = win_idx_reg;
    assign busy    = p_live_reg;

endmodule
